// File: design/pid_controller_antiwindup_unit_macros.svh
// Assertion macros used by the PID controller top-level design file.
`ifndef PID_CONTROLLER_ANTIWINDUP_UNIT_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge while reset is released.
`define PCAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pid controller assertion failed");

// Checked at every rising clock edge, reset included.
`define PCAU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("pid controller assertion failed");

`else

`define PCAU_ASSERT(label, clk, rst_n, prop)
`define PCAU_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: design/pcau_pkg.sv
// Types and constants of the PID controller with integral clamp and anti-windup.
package pcau_pkg;

  // Field and arithmetic widths.
  localparam int unsigned SampleW      = 16;
  localparam int unsigned GainW        = 16;
  localparam int unsigned GainFracBits = 8;
  localparam int unsigned LimitW       = 15;
  localparam int unsigned OutW         = 16;
  localparam int unsigned ErrW         = SampleW + 1;
  localparam int unsigned DiffW        = ErrW + 1;
  localparam int unsigned ProdPiW      = GainW + ErrW;
  localparam int unsigned ProdDW       = GainW + DiffW;
  localparam int unsigned TermPiW      = ProdPiW - GainFracBits;
  localparam int unsigned TermDW       = ProdDW - GainFracBits;
  localparam int unsigned IsumW        = TermPiW + 1;
  localparam int unsigned SumW         = TermDW + 2;
  localparam int unsigned CmpW         = OutW + 1;

  // Configuration port geometry.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register reset values.
  localparam logic [LimitW-1:0] LimitReset = {LimitW{1'b1}};

  // Register indexes.
  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_OUTPUT_LIMIT   = 3'd3,
    REG_INTEGRAL_BOUND = 3'd4,
    REG_WINDUP_ENABLE  = 3'd5
  } reg_idx_e;

  // Input request payload.
  typedef struct packed {
    logic signed [SampleW-1:0] target;
    logic signed [SampleW-1:0] measured;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic signed [OutW-1:0] drive;
    logic signed [OutW-1:0] integral_term;
    logic                   saturated;
  } out_res_t;

endpackage

// File: design/pid_controller_antiwindup_unit.sv
// PID controller top level: register file, input register, datapath and result register.

// Fixed-point PID controller. Each request carries a setpoint and a measurement;
// the block returns one result per request with the clamped drive, the integral
// term after its clamp and anti-windup, and a flag that tells whether the drive
// was clamped. A request is taken into an input register and its result lands in
// the result register when that register is free or drained; the block sustains
// one request per cycle while the result channel does not stall. Rate is set by
// the single combinational pass between those two registers: three multipliers in
// parallel, the integral clamp and the output clamp, with the integral and prior
// drive fed back from that same pass. Gains are signed Q8.8, products are shifted
// right arithmetically by eight. Writing any gain clears the integral, the prior
// error and the prior drive. Registers are written over an APB-style port with
// pready tied high; reads return the stored value zero-extended to 32 bits.
module pid_controller_antiwindup_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pcau_pkg::in_req_t           in_data_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pcau_pkg::out_res_t          out_data_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcau_pkg::AddrW-1:0]  paddr,
  input  logic [pcau_pkg::DataW-1:0]  pwdata,
  output logic [pcau_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  // Configuration registers.
  logic signed [pcau_pkg::GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic        [pcau_pkg::LimitW-1:0] output_limit_q, integral_bound_q;
  logic                               windup_enable_q;

  // Controller state.
  logic signed [pcau_pkg::ErrW-1:0]   prior_error_q;
  logic signed [pcau_pkg::OutW-1:0]   integral_acc_q;
  logic signed [pcau_pkg::OutW-1:0]   prior_drive_q;

  // Pipeline registers.
  logic                               in_valid_q;
  pcau_pkg::in_req_t                  in_q;
  logic                               out_valid_q;
  pcau_pkg::out_res_t                 out_q;

  // Datapath signals.
  logic signed [pcau_pkg::ErrW-1:0]    err_c;
  logic signed [pcau_pkg::DiffW-1:0]   diff_c;
  logic signed [pcau_pkg::ProdPiW-1:0] prod_p_c, prod_i_c;
  logic signed [pcau_pkg::ProdDW-1:0]  prod_d_c;
  logic signed [pcau_pkg::TermPiW-1:0] term_p_c, term_i_c;
  logic signed [pcau_pkg::TermDW-1:0]  term_d_c;
  logic signed [pcau_pkg::IsumW-1:0]   isum_c, ibound_c;
  logic signed [pcau_pkg::OutW-1:0]    integ_clamp_c, integ_c;
  logic signed [pcau_pkg::CmpW-1:0]    pdrive_c, olimit_c;
  logic                                wind_hi_c, wind_lo_c, wind_zero_c;
  logic signed [pcau_pkg::SumW-1:0]    sum_c, slimit_c, drive_wide_c;
  logic signed [pcau_pkg::OutW-1:0]    drive_c;
  logic                                sat_c;

  // Handshake and configuration control.
  logic                                advance;
  logic                                cfg_wr;
  logic                                gain_wr;
  pcau_pkg::reg_idx_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = pcau_pkg::reg_idx_e'(paddr[pcau_pkg::AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign gain_wr = cfg_wr && (cfg_idx == pcau_pkg::REG_GAIN_P ||
                              cfg_idx == pcau_pkg::REG_GAIN_I ||
                              cfg_idx == pcau_pkg::REG_GAIN_D);

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q         <= '0;
      gain_i_q         <= '0;
      gain_d_q         <= '0;
      output_limit_q   <= pcau_pkg::LimitReset;
      integral_bound_q <= pcau_pkg::LimitReset;
      windup_enable_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pcau_pkg::REG_GAIN_P:         gain_p_q <= pwdata[pcau_pkg::GainW-1:0];
        pcau_pkg::REG_GAIN_I:         gain_i_q <= pwdata[pcau_pkg::GainW-1:0];
        pcau_pkg::REG_GAIN_D:         gain_d_q <= pwdata[pcau_pkg::GainW-1:0];
        pcau_pkg::REG_OUTPUT_LIMIT:   output_limit_q <= pwdata[pcau_pkg::LimitW-1:0];
        pcau_pkg::REG_INTEGRAL_BOUND: integral_bound_q <= pwdata[pcau_pkg::LimitW-1:0];
        pcau_pkg::REG_WINDUP_ENABLE:  windup_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      pcau_pkg::REG_GAIN_P:         prdata = pcau_pkg::DataW'(unsigned'(gain_p_q));
      pcau_pkg::REG_GAIN_I:         prdata = pcau_pkg::DataW'(unsigned'(gain_i_q));
      pcau_pkg::REG_GAIN_D:         prdata = pcau_pkg::DataW'(unsigned'(gain_d_q));
      pcau_pkg::REG_OUTPUT_LIMIT:   prdata = pcau_pkg::DataW'(output_limit_q);
      pcau_pkg::REG_INTEGRAL_BOUND: prdata = pcau_pkg::DataW'(integral_bound_q);
      pcau_pkg::REG_WINDUP_ENABLE:  prdata = pcau_pkg::DataW'(windup_enable_q);
      default:                      prdata = '0;
    endcase
  end

  // The input register moves on whenever the result register is free or drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Error, difference and the three gain products.
  assign err_c    = pcau_pkg::ErrW'(in_q.target) - pcau_pkg::ErrW'(in_q.measured);
  assign diff_c   = pcau_pkg::DiffW'(err_c) - pcau_pkg::DiffW'(prior_error_q);
  assign prod_p_c = pcau_pkg::ProdPiW'(gain_p_q) * pcau_pkg::ProdPiW'(err_c);
  assign prod_i_c = pcau_pkg::ProdPiW'(gain_i_q) * pcau_pkg::ProdPiW'(err_c);
  assign prod_d_c = pcau_pkg::ProdDW'(gain_d_q) * pcau_pkg::ProdDW'(diff_c);
  assign term_p_c = pcau_pkg::TermPiW'(prod_p_c >>> pcau_pkg::GainFracBits);
  assign term_i_c = pcau_pkg::TermPiW'(prod_i_c >>> pcau_pkg::GainFracBits);
  assign term_d_c = pcau_pkg::TermDW'(prod_d_c >>> pcau_pkg::GainFracBits);

  // Integral update with its symmetric clamp.
  assign isum_c   = pcau_pkg::IsumW'(integral_acc_q) + pcau_pkg::IsumW'(term_i_c);
  assign ibound_c = pcau_pkg::IsumW'(signed'({1'b0, integral_bound_q}));

  always_comb begin
    if (isum_c > ibound_c) begin
      integ_clamp_c = pcau_pkg::OutW'(ibound_c);
    end else if (isum_c < -ibound_c) begin
      integ_clamp_c = pcau_pkg::OutW'(-ibound_c);
    end else begin
      integ_clamp_c = pcau_pkg::OutW'(isum_c);
    end
  end

  // Anti-windup: previous drive at a limit with the error pushing further out.
  assign pdrive_c    = pcau_pkg::CmpW'(prior_drive_q);
  assign olimit_c    = pcau_pkg::CmpW'(signed'({1'b0, output_limit_q}));
  assign wind_hi_c   = (pdrive_c >= olimit_c) && (prior_drive_q > 0) && (err_c > 0);
  assign wind_lo_c   = (pdrive_c <= -olimit_c) && (prior_drive_q < 0) && (err_c < 0);
  assign wind_zero_c = windup_enable_q && (gain_i_q != 0) && (wind_hi_c || wind_lo_c);
  assign integ_c     = wind_zero_c ? '0 : integ_clamp_c;

  // Output sum and its symmetric clamp.
  assign sum_c    = pcau_pkg::SumW'(term_p_c) + pcau_pkg::SumW'(integ_c) +
                    pcau_pkg::SumW'(term_d_c);
  assign slimit_c = pcau_pkg::SumW'(signed'({1'b0, output_limit_q}));

  always_comb begin
    if (sum_c > slimit_c) begin
      drive_wide_c = slimit_c;
    end else if (sum_c < -slimit_c) begin
      drive_wide_c = -slimit_c;
    end else begin
      drive_wide_c = sum_c;
    end
  end

  assign drive_c = pcau_pkg::OutW'(drive_wide_c);
  assign sat_c   = (drive_wide_c != sum_c);

  // Controller state is cleared by a gain write and otherwise follows each item as it enters the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_error_q  <= '0;
      integral_acc_q <= '0;
      prior_drive_q  <= '0;
    end else if (gain_wr) begin
      prior_error_q  <= '0;
      integral_acc_q <= '0;
      prior_drive_q  <= '0;
    end else if (in_valid_q && advance) begin
      prior_error_q  <= err_c;
      integral_acc_q <= integ_c;
      prior_drive_q  <= drive_c;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_q.drive         <= drive_c;
      out_q.integral_term <= integ_c;
      out_q.saturated     <= sat_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "pid_controller_antiwindup_unit_macros.svh"

  // A gain write leaves all controller state cleared.
  `PCAU_ASSERT(a_gain_clears_state, clk_i, rst_ni, gain_wr |=> (prior_error_q == 0 && integral_acc_q == 0 && prior_drive_q == 0))

  // An item in the input register always reaches the result register when it moves.
  `PCAU_ASSERT(a_item_moves, clk_i, rst_ni, (in_valid_q && advance) |=> out_valid_q)

  // The integral sent out never leaves its bound.
  `PCAU_ASSERT(a_integ_bounded, clk_i, rst_ni, in_valid_q |-> (integ_c <= $signed({1'b0, integral_bound_q}) && integ_c >= -$signed({1'b0, integral_bound_q})))

  // A clamped drive sits exactly at one of the output limits.
  `PCAU_ASSERT(a_sat_at_limit, clk_i, rst_ni, (in_valid_q && sat_c) |-> (drive_wide_c == slimit_c || drive_wide_c == -slimit_c))

  // Back-pressure only when both registers are full and the result is stalled.
  `PCAU_ASSERT(a_ready_stall, clk_i, rst_ni, !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))

endmodule
